// ===== sv/raie_pkg.sv =====
package raie_pkg;

    localparam int DATA_W       = 8;
    localparam int REG_IDX_W    = 4;
    localparam int MODE_W       = 3;
    localparam int NUM_REGS_DEF = 16;
    localparam int STEP_CNT     = 8;
    localparam int STEP_CNT_W   = $clog2(STEP_CNT);

    typedef enum logic [MODE_W-1:0] {
        MODE_MOVE = 3'd0,
        MODE_ADD  = 3'd1,
        MODE_SUB  = 3'd2,
        MODE_MUL  = 3'd3,
        MODE_DIV  = 3'd4,
        MODE_REM  = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CALC
    } t_state;

    typedef enum logic [1:0] {
        A_IDLE,
        A_RUN,
        A_DONE
    } t_alu_state;

    typedef struct packed {
        logic  start;
        logic  ack;
        t_mode mode;
    } t_alu_req;

    typedef struct packed {
        logic done;
        logic dz;
    } t_alu_rsp;

endpackage

// ===== sv/register_alu_instruction_exec_top.sv =====
// Multiply, divide and remainder run 8 steps of the shared adder in the
// iterative unit; the other modes and a zero divisor skip the iteration.
// One request is in flight at a time; a new request is taken once the result
// is in the output stage, which it enters only when that stage is free.
// Reset: synchronous, active low; clears the file's valid bits, so every register reads zero.
module register_alu_instruction_exec_top
    import raie_pkg::*;
#(
    parameter int NUM_REGS = NUM_REGS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [MODE_W-1:0]        i_mode,
    input  logic [REG_IDX_W-1:0]     i_dest_reg,
    input  logic                     i_operand_is_register,
    input  logic [REG_IDX_W-1:0]     i_source_reg,
    input  logic signed [DATA_W-1:0] i_immediate,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [REG_IDX_W-1:0]     o_written_reg,
    output logic signed [DATA_W-1:0] o_written_value,
    output logic                     o_divide_by_zero
);

    t_state r_st, n_st;
    t_mode  r_mode;
    logic [REG_IDX_W-1:0]     r_dest;
    logic                     r_use_reg;
    logic signed [DATA_W-1:0] r_imm;

    logic                     r_out_valid, n_out_valid;
    logic [REG_IDX_W-1:0]     r_out_reg;
    logic signed [DATA_W-1:0] r_out_val;
    logic                     r_out_dz;

    logic signed [DATA_W-1:0] rd_a;
    logic signed [DATA_W-1:0] rd_b;
    logic signed [DATA_W-1:0] alu_b;
    logic signed [DATA_W-1:0] alu_res;
    t_alu_req alu_req;
    t_alu_rsp alu_rsp;
    logic     accept;
    logic     finish;

    raie_regfile #(
        .NUM_REGS (NUM_REGS)
    ) u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_raddr_a (i_dest_reg),
        .i_raddr_b (i_source_reg),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b),
        .i_we      (finish),
        .i_waddr   (r_dest),
        .i_wdata   (alu_res)
    );

    raie_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (alu_req),
        .i_a      (rd_a),
        .i_b      (alu_b),
        .o_rsp    (alu_rsp),
        .o_result (alu_res)
    );

    assign alu_b = r_use_reg ? rd_b : r_imm;

    always_comb begin
        n_st          = r_st;
        o_ready       = 1'b0;
        accept        = 1'b0;
        finish        = 1'b0;
        alu_req.start = 1'b0;
        alu_req.ack   = 1'b0;
        alu_req.mode  = r_mode;

        unique case (r_st)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    accept = 1'b1;
                    n_st   = S_READ;
                end
            end
            S_READ: begin
                // register reads land this cycle; launch the unit
                alu_req.start = 1'b1;
                n_st          = S_CALC;
            end
            S_CALC: begin
                // hold the result in the unit until the output stage frees up
                if (alu_rsp.done && (!r_out_valid || i_ready)) begin
                    finish      = 1'b1;
                    alu_req.ack = 1'b1;
                    n_st        = S_IDLE;
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (finish) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_st        <= n_st;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode    <= t_mode'(i_mode);
            r_dest    <= i_dest_reg;
            r_use_reg <= i_operand_is_register;
            r_imm     <= i_immediate;
        end
        if (finish) begin
            r_out_reg <= r_dest;
            r_out_val <= alu_res;
            r_out_dz  <= alu_rsp.dz;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_written_reg    = r_out_reg;
    assign o_written_value  = r_out_val;
    assign o_divide_by_zero = r_out_dz;

endmodule

// ===== sv/raie_regfile.sv =====
module raie_regfile
    import raie_pkg::*;
#(
    parameter int NUM_REGS = NUM_REGS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [REG_IDX_W-1:0]     i_raddr_a,
    input  logic [REG_IDX_W-1:0]     i_raddr_b,
    output logic signed [DATA_W-1:0] o_rdata_a,
    output logic signed [DATA_W-1:0] o_rdata_b,
    input  logic                     i_we,
    input  logic [REG_IDX_W-1:0]     i_waddr,
    input  logic signed [DATA_W-1:0] i_wdata
);

    localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    logic [DATA_W-1:0]   r_mem [NUM_REGS];
    logic [NUM_REGS-1:0] r_vld;
    logic signed [DATA_W-1:0] r_rdata_a;
    logic signed [DATA_W-1:0] r_rdata_b;

    logic hit_a;
    logic hit_b;
    logic hit_w;

    // indexes past the file read as zero and drop writes
    assign hit_a = ({1'b0, i_raddr_a} < (REG_IDX_W+1)'(NUM_REGS));
    assign hit_b = ({1'b0, i_raddr_b} < (REG_IDX_W+1)'(NUM_REGS));
    assign hit_w = ({1'b0, i_waddr}   < (REG_IDX_W+1)'(NUM_REGS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we && hit_w) begin
            r_vld[i_waddr[IDX_W-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we && hit_w) begin
            r_mem[i_waddr[IDX_W-1:0]] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hit_a && r_vld[i_raddr_a[IDX_W-1:0]]) begin
            r_rdata_a <= r_mem[i_raddr_a[IDX_W-1:0]];
        end else begin
            r_rdata_a <= '0;
        end
        if (hit_b && r_vld[i_raddr_b[IDX_W-1:0]]) begin
            r_rdata_b <= r_mem[i_raddr_b[IDX_W-1:0]];
        end else begin
            r_rdata_b <= '0;
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== sv/raie_alu.sv =====
module raie_alu
    import raie_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_alu_req                 i_req,
    input  logic signed [DATA_W-1:0] i_a,
    input  logic signed [DATA_W-1:0] i_b,
    output t_alu_rsp                 o_rsp,
    output logic signed [DATA_W-1:0] o_result
);

    localparam logic [STEP_CNT_W-1:0] STEP_LAST = STEP_CNT_W'(STEP_CNT - 1);

    t_alu_state r_st, n_st;
    t_mode      r_mode, n_mode;
    logic [STEP_CNT_W-1:0] r_cnt, n_cnt;
    logic [DATA_W-1:0] r_acc, n_acc;
    logic [DATA_W-1:0] r_x, n_x;
    logic [DATA_W-1:0] r_y, n_y;
    logic [DATA_W-1:0] r_rem, n_rem;
    logic r_neg_q, n_neg_q;
    logic r_neg_r, n_neg_r;
    logic r_dz, n_dz;

    logic [DATA_W+1:0] add_x;
    logic [DATA_W+1:0] add_y;
    logic [DATA_W+1:0] add_sum;
    logic              add_sub;
    logic [DATA_W:0]   div_sh;
    logic [DATA_W-1:0] abs_a;
    logic [DATA_W-1:0] abs_b;

    // the one adder shared by add, subtract and every multiply and divide step
    assign add_sum = add_x + (add_y ^ {(DATA_W+2){add_sub}})
                   + {{(DATA_W+1){1'b0}}, add_sub};

    assign div_sh = {r_rem, r_x[DATA_W-1]};
    assign abs_a  = i_a[DATA_W-1] ? (~i_a + 1'b1) : i_a;
    assign abs_b  = i_b[DATA_W-1] ? (~i_b + 1'b1) : i_b;

    always_comb begin
        n_st    = r_st;
        n_mode  = r_mode;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_x     = r_x;
        n_y     = r_y;
        n_rem   = r_rem;
        n_neg_q = r_neg_q;
        n_neg_r = r_neg_r;
        n_dz    = r_dz;
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;

        unique case (r_st)
            A_IDLE: begin
                if (i_req.start) begin
                    n_mode = i_req.mode;
                    n_cnt  = '0;
                    n_dz   = 1'b0;
                    n_st   = A_DONE;
                    unique case (i_req.mode)
                        MODE_MOVE: begin
                            n_acc = i_b;
                        end
                        MODE_ADD, MODE_SUB: begin
                            add_x   = {{2{i_a[DATA_W-1]}}, i_a};
                            add_y   = {{2{i_b[DATA_W-1]}}, i_b};
                            add_sub = (i_req.mode == MODE_SUB);
                            n_acc   = add_sum[DATA_W-1:0];
                        end
                        MODE_MUL: begin
                            n_acc = '0;
                            n_x   = i_a;
                            n_y   = i_b;
                            n_st  = A_RUN;
                        end
                        MODE_DIV, MODE_REM: begin
                            if (i_b == '0) begin
                                n_acc = i_a;
                                n_dz  = 1'b1;
                            end else begin
                                n_rem   = '0;
                                n_x     = abs_a;
                                n_y     = abs_b;
                                n_neg_q = i_a[DATA_W-1] ^ i_b[DATA_W-1];
                                n_neg_r = i_a[DATA_W-1];
                                n_st    = A_RUN;
                            end
                        end
                        default: begin
                            n_acc = i_a;
                        end
                    endcase
                end
            end
            A_RUN: begin
                if (r_mode == MODE_MUL) begin
                    // shift-add: low byte of the product wraps like the signed one
                    add_x = {2'b00, r_acc};
                    add_y = {2'b00, (r_y[0] ? r_x : {DATA_W{1'b0}})};
                    n_acc = add_sum[DATA_W-1:0];
                    n_x   = {r_x[DATA_W-2:0], 1'b0};
                    n_y   = {1'b0, r_y[DATA_W-1:1]};
                end else begin
                    // restoring divide on magnitudes, one quotient bit per step
                    add_x   = {1'b0, div_sh};
                    add_y   = {2'b00, r_y};
                    add_sub = 1'b1;
                    if (!add_sum[DATA_W+1]) begin
                        n_rem = add_sum[DATA_W-1:0];
                        n_x   = {r_x[DATA_W-2:0], 1'b1};
                    end else begin
                        n_rem = div_sh[DATA_W-1:0];
                        n_x   = {r_x[DATA_W-2:0], 1'b0};
                    end
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == STEP_LAST) begin
                    n_st = A_DONE;
                end
            end
            A_DONE: begin
                if (i_req.ack) begin
                    n_st = A_IDLE;
                end
            end
            default: begin
                n_st = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= A_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode  <= n_mode;
        r_cnt   <= n_cnt;
        r_acc   <= n_acc;
        r_x     <= n_x;
        r_y     <= n_y;
        r_rem   <= n_rem;
        r_neg_q <= n_neg_q;
        r_neg_r <= n_neg_r;
        r_dz    <= n_dz;
    end

    // apply signs: quotient takes the xor of signs, remainder the dividend's
    always_comb begin
        o_result = r_acc;
        if (!r_dz) begin
            if (r_mode == MODE_DIV) begin
                o_result = r_neg_q ? (~r_x + 1'b1) : r_x;
            end else if (r_mode == MODE_REM) begin
                o_result = r_neg_r ? (~r_rem + 1'b1) : r_rem;
            end
        end
    end

    assign o_rsp.done = (r_st == A_DONE);
    assign o_rsp.dz   = r_dz;

endmodule

// ===== tb/tb_register_alu_instruction_exec_top.sv =====
module tb_register_alu_instruction_exec_top;
    import raie_pkg::*;

    localparam int                CYCLE_LIMIT  = 400000;
    localparam int                HOLD_CYCLES  = 400;
    localparam int                DRAIN_CYCLES = 24;
    localparam logic [MODE_W-1:0] MODE_RSVD6   = 3'd6;
    localparam logic [MODE_W-1:0] MODE_RSVD7   = 3'd7;

    typedef struct {
        logic [REG_IDX_W-1:0]     reg_idx;
        logic signed [DATA_W-1:0] value;
        logic                     dz;
    } t_reg_write;

    class regfile_scoreboard;
        logic signed [DATA_W-1:0] regs [NUM_REGS_DEF];
        t_reg_write               pending_writes[$];
        int                       errors;

        function new();
            foreach (regs[i]) regs[i] = '0;
            errors = 0;
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH: %s", msg);
        endtask

        // Execute one instruction on the shadow file and queue the write it produces.
        function void note_instr(logic [MODE_W-1:0] mode, logic [REG_IDX_W-1:0] dst,
                                 logic use_reg, logic [REG_IDX_W-1:0] src,
                                 logic signed [DATA_W-1:0] imm);
            int         a;
            int         b;
            int         r;
            logic       dz;
            t_reg_write w;
            a  = regs[dst];
            b  = use_reg ? regs[src] : imm;
            r  = a;
            dz = 1'b0;
            case (mode)
                MODE_MOVE: r = b;
                MODE_ADD:  r = a + b;
                MODE_SUB:  r = a - b;
                MODE_MUL:  r = a * b;
                MODE_DIV: begin
                    if (b == 0) dz = 1'b1;
                    else r = a / b;
                end
                MODE_REM: begin
                    if (b == 0) dz = 1'b1;
                    else r = a % b;
                end
                default: ;
            endcase
            regs[dst] = r[DATA_W-1:0];
            w.reg_idx = dst;
            w.value   = r[DATA_W-1:0];
            w.dz      = dz;
            pending_writes.push_back(w);
        endfunction

        task check_write(logic [REG_IDX_W-1:0] got_reg, logic signed [DATA_W-1:0] got_val,
                         logic got_dz);
            t_reg_write want;
            if (pending_writes.size() == 0) begin
                report($sformatf("result r%0d=%0d with no request outstanding",
                                 got_reg, got_val));
                return;
            end
            want = pending_writes.pop_front();
            if (got_reg !== want.reg_idx)
                report($sformatf("written_reg %0d, want %0d", got_reg, want.reg_idx));
            if (got_val !== want.value)
                report($sformatf("written_value %0d, want %0d (r%0d)",
                                 got_val, want.value, want.reg_idx));
            if (got_dz !== want.dz)
                report($sformatf("divide_by_zero %0b, want %0b (r%0d)",
                                 got_dz, want.dz, want.reg_idx));
        endtask
    endclass

    logic                     i_clk                 = 1'b0;
    logic                     i_rst_n               = 1'b0;
    logic                     i_valid               = 1'b0;
    logic                     o_ready;
    logic [MODE_W-1:0]        i_mode                = MODE_MOVE;
    logic [REG_IDX_W-1:0]     i_dest_reg            = '0;
    logic                     i_operand_is_register = 1'b0;
    logic [REG_IDX_W-1:0]     i_source_reg          = '0;
    logic signed [DATA_W-1:0] i_immediate           = '0;
    logic                     o_valid;
    logic                     i_ready               = 1'b0;
    logic [REG_IDX_W-1:0]     o_written_reg;
    logic signed [DATA_W-1:0] o_written_value;
    logic                     o_divide_by_zero;

    regfile_scoreboard sb;
    int                stall_pct    = 0;
    bit                hold_pending = 1'b0;
    int                cycle_count  = 0;

    register_alu_instruction_exec_top DUT (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_ready               (o_ready),
        .i_mode                (i_mode),
        .i_dest_reg            (i_dest_reg),
        .i_operand_is_register (i_operand_is_register),
        .i_source_reg          (i_source_reg),
        .i_immediate           (i_immediate),
        .o_valid               (o_valid),
        .i_ready               (i_ready),
        .o_written_reg         (o_written_reg),
        .o_written_value       (o_written_value),
        .o_divide_by_zero      (o_divide_by_zero)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: check every accepted write, then pick ready for the next cycle.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready)
                sb.check_write(o_written_reg, o_written_value, o_divide_by_zero);
            if (hold_pending) begin
                // Hold off long enough for the block to back up into its input.
                hold_pending = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Leaves valid high on return; the caller drops it when idling.
    task automatic send_instr(input logic [MODE_W-1:0] mode, input logic [REG_IDX_W-1:0] dst,
                              input logic use_reg, input logic [REG_IDX_W-1:0] src,
                              input logic signed [DATA_W-1:0] imm);
        i_valid               <= 1'b1;
        i_mode                <= mode;
        i_dest_reg            <= dst;
        i_operand_is_register <= use_reg;
        i_source_reg          <= src;
        i_immediate           <= imm;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_instr(mode, dst, use_reg, src, imm);
    endtask

    task automatic run_random(input int count, input int idle_pct, input int stall);
        logic [MODE_W-1:0]        mode;
        logic signed [DATA_W-1:0] imm;
        int                       pick;
        stall_pct = stall;
        repeat (count) begin
            while ($urandom_range(99) < idle_pct) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
            pick = $urandom_range(99);
            if (pick < 4)
                mode = pick[0] ? MODE_RSVD7 : MODE_RSVD6;
            else
                mode = MODE_W'($urandom_range(5));
            // Bias toward the corner values that matter for wrap and divide.
            case ($urandom_range(11))
                0:       imm = 0;
                1:       imm = 1;
                2:       imm = -1;
                3:       imm = 127;
                4:       imm = -128;
                default: imm = DATA_W'($urandom);
            endcase
            send_instr(mode, REG_IDX_W'($urandom_range(15)), 1'($urandom_range(1)),
                       REG_IDX_W'($urandom_range(15)), imm);
        end
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        stall_pct = 0;

        send_instr(MODE_MOVE,  4'd0,  1'b0, 4'd0,  127);
        send_instr(MODE_MOVE,  4'd15, 1'b0, 4'd15, -128);
        send_instr(MODE_MOVE,  4'd1,  1'b0, 4'd0,  -1);
        send_instr(MODE_ADD,   4'd0,  1'b0, 4'd0,  1);
        send_instr(MODE_SUB,   4'd15, 1'b0, 4'd0,  1);
        send_instr(MODE_MUL,   4'd1,  1'b1, 4'd1,  0);
        send_instr(MODE_MOVE,  4'd2,  1'b0, 4'd0,  -128);
        send_instr(MODE_DIV,   4'd2,  1'b0, 4'd0,  -1);
        send_instr(MODE_MOVE,  4'd3,  1'b0, 4'd0,  -128);
        send_instr(MODE_MOVE,  4'd9,  1'b0, 4'd0,  -1);
        send_instr(MODE_REM,   4'd3,  1'b1, 4'd9,  0);
        send_instr(MODE_DIV,   4'd0,  1'b0, 4'd0,  0);
        send_instr(MODE_REM,   4'd1,  1'b1, 4'd4,  85);
        send_instr(MODE_MOVE,  4'd5,  1'b0, 4'd0,  -7);
        send_instr(MODE_DIV,   4'd5,  1'b0, 4'd0,  2);
        send_instr(MODE_MOVE,  4'd6,  1'b0, 4'd0,  -7);
        send_instr(MODE_REM,   4'd6,  1'b0, 4'd0,  2);
        send_instr(MODE_MUL,   4'd15, 1'b0, 4'd0,  127);
        send_instr(MODE_RSVD6, 4'd0,  1'b1, 4'd15, -86);
        send_instr(MODE_RSVD7, 4'd15, 1'b0, 4'd15, -1);
        send_instr(MODE_ADD,   4'd14, 1'b1, 4'd15, 0);
        send_instr(MODE_MOVE,  4'd7,  1'b1, 4'd0,  0);
        send_instr(MODE_SUB,   4'd8,  1'b0, 4'd0,  -128);
        send_instr(MODE_DIV,   4'd10, 1'b1, 4'd2,  0);

        run_random(330, 0, 0);
        run_random(320, 66, 0);
        run_random(320, 0, 66);
        run_random(320, 13, 13);

        // Stall the result side while requests keep coming.
        stall_pct    = 0;
        hold_pending = 1'b1;
        run_random(60, 0, 0);
        i_valid <= 1'b0;

        while (sb.pending_writes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
